// ===== rtl/dcs_pkg.sv =====
package dcs_pkg;

   localparam int MAX_NODES   = 16;
   localparam int MAX_GRAPHS  = 4;
   localparam int SLOTS       = MAX_NODES * (MAX_NODES - 1) / 2;
   localparam int IDX_W       = $clog2(MAX_NODES);
   localparam int NODE_W      = $clog2(MAX_NODES + 1);
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int GCNT_W      = $clog2(MAX_GRAPHS + 1);
   localparam int ID_W        = 32;
   localparam int MASK_W      = 16;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_SELF = 2'd2
   } status_type;

   typedef struct packed {
      logic             rd;
      logic             we;
      logic [IDX_W-1:0] addr;
      logic [ID_W-1:0]  wdata;
   } id_req_type;

   typedef struct packed {
      logic                  rd;
      logic                  we;
      logic [SLOT_W-1:0]     addr;
      logic [MAX_GRAPHS-1:0] wdata;
   } edge_req_type;

   // slot of an unordered pair: hi*(hi-1)/2 + lo
   function automatic logic [SLOT_W-1:0] pair_slot(input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
      logic [IDX_W-1:0]   hi;
      logic [IDX_W-1:0]   lo;
      logic [2*IDX_W-1:0] prod;
      hi   = (a > b) ? a : b;
      lo   = (a > b) ? b : a;
      prod = (2*IDX_W)'(hi) * (2*IDX_W)'(hi - IDX_W'(1));
      return SLOT_W'(prod >> 1) + SLOT_W'(lo);
   endfunction

endpackage

// ===== rtl/densest_common_subgraph_search_core.sv =====
// Add-edge transaction: each id table entry is read (S_LOOK) and compared (S_CMPID), a new
//   id is appended in S_LOOK, then S_EDGE_RD and S_EDGE_WR read-modify-write the edge store.
// Search transaction: per nonzero mask, a one-read-per-cycle sweep of every edge store slot,
//   then S_DRAIN, S_MIN and S_CMP; a zero mask is skipped. One transaction at a time.
// Synchronous active-high reset clears node count and edge store valid bits, sets
//   graphs_in_use to 1; the id table holds no reset value.
module densest_common_subgraph_search_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_from_id,
   input  logic [31:0] req_to_id,
   input  logic [1:0]  req_graph_index,
   input  logic [15:0] req_first_mask,
   input  logic [15:0] req_last_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_best_mask,
   output logic [6:0]  rsp_best_edges,
   output logic [4:0]  rsp_best_nodes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_wdata
);

   localparam int IW = dcs_pkg::IDX_W;
   localparam int NW = dcs_pkg::NODE_W;
   localparam int SW = dcs_pkg::SLOT_W;
   localparam int CW = dcs_pkg::CNT_W;
   localparam int GW = dcs_pkg::GCNT_W;
   localparam int MG = dcs_pkg::MAX_GRAPHS;
   localparam int PW = CW + NW;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_CMPID, S_EDGE_RD, S_EDGE_WR,
      S_MASK, S_SWEEP, S_DRAIN, S_MIN, S_CMP, S_DONE
   } state_type;

   state_type                state_ff;
   logic [NW-1:0]            i_ff;
   logic                     which_ff;
   logic [IW-1:0]            a_ff, b_ff;
   logic [31:0]              from_ff, to_ff;
   logic [1:0]               graph_ff;
   logic [15:0]              m_ff, last_ff;
   dcs_pkg::status_type      status_ff;
   logic [15:0]              bmask_ff;
   logic [CW-1:0]            bedges_ff;
   logic [NW-1:0]            bnodes_ff;
   logic [NW-1:0]            nodes_ff;
   logic [GW-1:0]            graphs_ff;
   logic [SW-1:0]            slot_ff;
   logic [IW-1:0]            hi_ff, lo_ff;
   logic                     pend_ff;
   logic                     pend_in;
   logic [CW-1:0]            cnt_ff [MG];
   logic [CW-1:0]            e_ff;
   logic [NW-1:0]            n_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [15:0]              rsp_mask_ff;
   logic [6:0]               rsp_edges_ff;
   logic [4:0]               rsp_nodes_ff;

   dcs_pkg::id_req_type      id_req;
   dcs_pkg::edge_req_type    edge_req;
   logic [31:0]              id_rdata;
   logic [MG-1:0]            edge_rdata;
   logic [GW-1:0]            ng;
   logic [CW-1:0]            emin;
   logic [31:0]              key;
   logic                     better;
   logic [PW-1:0]            lhs, rhs;

   dcs_id_ram u_id_ram (
      .clock (clock),
      .req   (id_req),
      .rdata (id_rdata)
   );

   dcs_edge_ram u_edge_ram (
      .clock (clock),
      .reset (reset),
      .req   (edge_req),
      .rdata (edge_rdata)
   );

   assign key = which_ff ? to_ff : from_ff;

   // count the pair being read this cycle when both ends are in the mask
   assign pend_in = (state_ff == S_SWEEP) && (NW'(hi_ff) < nodes_ff) &&
                    m_ff[hi_ff] && m_ff[lo_ff];

   always_comb begin
      id_req = '0;
      if (state_ff == S_LOOK) begin
         if (i_ff == nodes_ff) begin
            id_req.we    = (int'(nodes_ff) < dcs_pkg::MAX_NODES);
            id_req.addr  = nodes_ff[IW-1:0];
            id_req.wdata = key;
         end else begin
            id_req.rd   = 1'b1;
            id_req.addr = i_ff[IW-1:0];
         end
      end
   end

   always_comb begin
      edge_req = '0;
      case (state_ff)
         S_EDGE_RD: begin
            edge_req.rd   = 1'b1;
            edge_req.addr = dcs_pkg::pair_slot(a_ff, b_ff);
         end
         S_EDGE_WR: begin
            edge_req.we    = 1'b1;
            edge_req.addr  = dcs_pkg::pair_slot(a_ff, b_ff);
            edge_req.wdata = edge_rdata | (MG'(1) << graph_ff);
         end
         S_SWEEP: begin
            edge_req.rd   = 1'b1;
            edge_req.addr = slot_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (graphs_ff == '0) begin
         ng = GW'(1);
      end else if (int'(graphs_ff) > MG) begin
         ng = GW'(MG);
      end else begin
         ng = graphs_ff;
      end
      emin = cnt_ff[0];
      for (int g = 1; g < MG; g++) begin
         if (g < int'(ng) && cnt_ff[g] < emin) begin
            emin = cnt_ff[g];
         end
      end
      lhs    = PW'(e_ff) * PW'(bnodes_ff);
      rhs    = PW'(bedges_ff) * PW'(n_ff);
      better = (bnodes_ff == '0) ? (e_ff != '0) : (lhs > rhs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nodes_ff     <= '0;
         graphs_ff    <= GW'(1);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            graphs_ff <= csr_wdata;
         end
         // drop the result once taken, unless a new one loads this cycle
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         // accumulate the edge word read in the previous cycle
         if (pend_ff) begin
            for (int g = 0; g < MG; g++) begin
               cnt_ff[g] <= cnt_ff[g] + CW'(edge_rdata[g]);
            end
         end
         pend_ff <= pend_in;

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  from_ff   <= req_from_id;
                  to_ff     <= req_to_id;
                  graph_ff  <= req_graph_index;
                  m_ff      <= req_first_mask;
                  last_ff   <= req_last_mask;
                  status_ff <= dcs_pkg::STATUS_OK;
                  bmask_ff  <= '0;
                  bedges_ff <= '0;
                  bnodes_ff <= '0;
                  i_ff      <= '0;
                  which_ff  <= 1'b0;
                  if (req_action) begin
                     state_ff <= (req_first_mask > req_last_mask) ? S_DONE : S_MASK;
                  end else if (int'(req_graph_index) >= MG) begin
                     state_ff <= S_DONE;
                  end else if (req_from_id == req_to_id) begin
                     status_ff <= dcs_pkg::STATUS_SELF;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_LOOK;
                  end
               end
            end
            S_LOOK: begin
               if (i_ff == nodes_ff) begin
                  if (int'(nodes_ff) >= dcs_pkg::MAX_NODES) begin
                     status_ff <= dcs_pkg::STATUS_FULL;
                     state_ff  <= S_DONE;
                  end else begin
                     // append the id
                     nodes_ff <= nodes_ff + NW'(1);
                     if (which_ff) begin
                        b_ff     <= nodes_ff[IW-1:0];
                        state_ff <= S_EDGE_RD;
                     end else begin
                        a_ff     <= nodes_ff[IW-1:0];
                        which_ff <= 1'b1;
                        i_ff     <= '0;
                     end
                  end
               end else begin
                  state_ff <= S_CMPID;
               end
            end
            S_CMPID: begin
               if (id_rdata == key) begin
                  if (which_ff) begin
                     b_ff     <= i_ff[IW-1:0];
                     state_ff <= S_EDGE_RD;
                  end else begin
                     a_ff     <= i_ff[IW-1:0];
                     which_ff <= 1'b1;
                     i_ff     <= '0;
                     state_ff <= S_LOOK;
                  end
               end else begin
                  i_ff     <= i_ff + NW'(1);
                  state_ff <= S_LOOK;
               end
            end
            S_EDGE_RD: state_ff <= S_EDGE_WR;
            S_EDGE_WR: state_ff <= S_DONE;
            S_MASK: begin
               if (m_ff == '0) begin
                  if (m_ff == last_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     m_ff <= m_ff + 16'd1;
                  end
               end else begin
                  for (int g = 0; g < MG; g++) begin
                     cnt_ff[g] <= '0;
                  end
                  slot_ff  <= '0;
                  hi_ff    <= IW'(1);
                  lo_ff    <= '0;
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               if (int'(slot_ff) == dcs_pkg::SLOTS - 1) begin
                  state_ff <= S_DRAIN;
               end else begin
                  slot_ff <= slot_ff + SW'(1);
                  if (lo_ff == hi_ff - IW'(1)) begin
                     hi_ff <= hi_ff + IW'(1);
                     lo_ff <= '0;
                  end else begin
                     lo_ff <= lo_ff + IW'(1);
                  end
               end
            end
            S_DRAIN: state_ff <= S_MIN;
            S_MIN: begin
               e_ff     <= emin;
               n_ff     <= NW'($countones(m_ff));
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (better) begin
                  bmask_ff  <= m_ff;
                  bedges_ff <= e_ff;
                  bnodes_ff <= n_ff;
               end
               if (m_ff == last_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  m_ff     <= m_ff + 16'd1;
                  state_ff <= S_MASK;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_mask_ff   <= bmask_ff;
                  rsp_edges_ff  <= 7'(bedges_ff);
                  rsp_nodes_ff  <= 5'(bnodes_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_best_mask  = rsp_mask_ff;
   assign rsp_best_edges = rsp_edges_ff;
   assign rsp_best_nodes = rsp_nodes_ff;

   a_nodes_bound: assert property (@(posedge clock) disable iff (reset)
      int'(nodes_ff) <= dcs_pkg::MAX_NODES)
      else $error("node count beyond table depth");

   a_self_edge: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_action && req_from_id == req_to_id)
      |=> (state_ff == S_DONE && status_ff == dcs_pkg::STATUS_SELF))
      else $error("self edge not flagged");

   a_best_nodes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_edges_ff == '0 || rsp_nodes_ff != '0))
      else $error("best edges without nodes");

endmodule

// ===== rtl/dcs_id_ram.sv =====
module dcs_id_ram (
   input  logic                    clock,
   input  dcs_pkg::id_req_type     req,
   output logic [dcs_pkg::ID_W-1:0] rdata
);

   logic [dcs_pkg::ID_W-1:0] mem [dcs_pkg::MAX_NODES];
   logic [dcs_pkg::ID_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dcs_edge_ram.sv =====
module dcs_edge_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  dcs_pkg::edge_req_type         req,
   output logic [dcs_pkg::MAX_GRAPHS-1:0] rdata
);

   logic [dcs_pkg::MAX_GRAPHS-1:0] mem [dcs_pkg::SLOTS];
   logic [dcs_pkg::SLOTS-1:0]      valid_ff;
   logic [dcs_pkg::MAX_GRAPHS-1:0] rdata_ff;
   logic                           rvalid_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd) begin
         rdata_ff <= mem[req.addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (req.we) begin
            valid_ff[req.addr] <= 1'b1;
         end
         if (req.rd) begin
            rvalid_ff <= valid_ff[req.addr];
         end
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (req.rd || req.we) |-> (int'(req.addr) < dcs_pkg::SLOTS))
      else $error("edge store address out of range");

   a_no_rw_same: assert property (@(posedge clock) disable iff (reset)
      !(req.rd && req.we))
      else $error("edge store read and write in one cycle");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      req.we |=> valid_ff[$past(req.addr)])
      else $error("edge write did not mark entry valid");

endmodule
